FILE: sv/spm_pkg.sv
`default_nettype none

package spm_pkg;

  // Widest pattern the window is built for
  localparam int unsigned MaxPatternDef = 16;

  // Code that stands in for a masked byte
  localparam logic [7:0] StarByte = 8'd42;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned PlenW    = 5;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatLow  = 2'd0,
    CfgPatHigh = 2'd1,
    CfgPatLen  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } spm_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       final_byte;
  } spm_out_t;

endpackage

`default_nettype wire

FILE: sv/stream_pattern_masker.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        sink       in_valid_i/in_stall_o   spm_in_t: data_byte, end_of_text
// out       source     out_valid_o/out_stall_i spm_out_t: out_byte, final_byte
// cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i (64 bits)
//
// An unmatched byte enters the window, and the oldest byte leaves in the same
// cycle. A match emits pattern-length stars, one per cycle, from the single
// output register. End of text flushes what is left in the window at one byte
// per cycle. Stalls on the output freeze the whole core. A two-entry input
// buffer keeps in_stall_o registered.
// Reset clears control state and loads pattern_length with 1. Window bytes are
// not reset. Only bytes below the fill count are ever read.

module stream_pattern_masker #(
  parameter int unsigned MaxPattern = spm_pkg::MaxPatternDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire spm_pkg::spm_in_t              in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output spm_pkg::spm_out_t                  out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [spm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [spm_pkg::CfgDataW-1:0]  cfg_data_i
);
  import spm_pkg::*;

  localparam int unsigned FillW = $clog2(MaxPattern + 1);
  localparam int unsigned WinW  = MaxPattern * 8;

  // Configuration registers
  logic [CfgDataW-1:0]     pat_lo_q, pat_hi_q;
  logic [PlenW-1:0]        plen_q;
  logic [2*CfgDataW-1:0]   pat_all;
  logic [FillW-1:0]        len;

  // Input buffer: a main slot plus a skid slot
  spm_in_t                 in_q, sk_q;
  logic                    in_vld_q, sk_vld_q;
  logic                    in_acc;

  // Window and sequencing state
  logic [WinW-1:0]         win_q, win_app, w_sel, w_n;
  logic [FillW-1:0]        fill_q, f_sel, f_n;
  logic [FillW-1:0]        star_q, star_n, sh;
  logic                    busy_q, busy_n;
  logic                    last_q, l_sel;
  logic                    work, take, match, emit, fin;
  logic [7:0]              ob;

  // Output register
  spm_out_t                out_q;
  logic                    out_vld_q;
  logic                    out_free;

  assign cfg_ready_o = 1'b1;
  assign pat_all     = {pat_hi_q, pat_lo_q};

  // A length of zero acts as one; anything past the window depth is clamped.
  always_comb begin
    if (plen_q == '0) begin
      len = FillW'(1);
    end else if (plen_q > PlenW'(MaxPattern)) begin
      len = FillW'(MaxPattern);
    end else begin
      len = plen_q[FillW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      plen_q   <= PlenW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgPatLow:  pat_lo_q <= cfg_data_i;
        CfgPatHigh: pat_hi_q <= cfg_data_i;
        CfgPatLen:  plen_q   <= cfg_data_i[PlenW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input buffer. Stall only when the skid slot is taken, so the input side
  // never waits on out_stall_i combinationally.
  // ---------------------------------------------------------------------------
  assign in_stall_o = sk_vld_q;
  assign in_acc     = in_valid_i && !sk_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      sk_vld_q <= 1'b0;
    end else if (take) begin
      if (sk_vld_q) begin
        sk_vld_q <= 1'b0;
      end else begin
        in_vld_q <= in_acc;
      end
    end else if (in_acc) begin
      if (in_vld_q) begin
        sk_vld_q <= 1'b1;
      end else begin
        in_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (sk_vld_q) begin
        in_q <= sk_q;
      end else if (in_acc) begin
        in_q <= in_data_i;
      end
    end else if (in_acc) begin
      if (in_vld_q) begin
        sk_q <= in_data_i;
      end else begin
        in_q <= in_data_i;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Core. Each cycle the output is free, it emits one pending star or works on
  // the window: front match -> first star and drop pattern length; no match ->
  // oldest byte out and shift by one; end of text with a short tail -> flush
  // one byte. A new byte is only taken when the last transaction's work is done.
  // ---------------------------------------------------------------------------
  assign out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    win_app = win_q;
    for (int i = 0; i < MaxPattern; i++) begin
      if (fill_q == FillW'(i)) begin
        win_app[i*8 +: 8] = in_q.data_byte;
      end
    end
  end

  always_comb begin
    work  = 1'b0;
    take  = 1'b0;
    w_sel = win_q;
    f_sel = fill_q;
    l_sel = last_q;
    if (out_free && star_q == '0) begin
      if (busy_q) begin
        work = 1'b1;
      end else if (in_vld_q) begin
        work  = 1'b1;
        take  = 1'b1;
        w_sel = win_app;
        f_sel = fill_q + FillW'(1);
        l_sel = in_q.end_of_text;
      end
    end
  end

  always_comb begin
    match = 1'b1;
    for (int k = 0; k < MaxPattern; k++) begin
      if (FillW'(k) < len && w_sel[k*8 +: 8] != pat_all[k*8 +: 8]) begin
        match = 1'b0;
      end
    end
  end

  // When idle, held bytes wait for the next transaction, even after a
  // pattern change.
  always_comb begin
    emit   = 1'b0;
    ob     = w_sel[7:0];
    star_n = star_q;
    sh     = '0;
    if (star_q != '0) begin
      emit   = 1'b1;
      ob     = StarByte;
      star_n = star_q - FillW'(1);
    end else if (work) begin
      if (f_sel >= len) begin
        emit = 1'b1;
        if (match) begin
          ob     = StarByte;
          star_n = len - FillW'(1);
          sh     = len;
        end else begin
          sh = FillW'(1);
        end
      end else if (l_sel && f_sel != '0) begin
        emit = 1'b1;
        sh   = FillW'(1);
      end
    end
    f_n    = f_sel - sh;
    w_n    = w_sel >> {sh, 3'b000};
    busy_n = (work || star_q != '0) &&
             ((star_n != '0) || (f_n >= len) || (l_sel && f_n != '0));
    fin    = l_sel && (star_n == '0) && (f_n == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      star_q    <= '0;
      busy_q    <= 1'b0;
      last_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      fill_q    <= f_n;
      star_q    <= star_n;
      busy_q    <= busy_n;
      last_q    <= l_sel;
      out_vld_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      win_q <= w_n;
      if (emit) begin
        out_q.out_byte   <= ob;
        out_q.final_byte <= fin;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: sv/spm_checker.sv
`default_nettype none

module spm_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_o,
  input  wire spm_pkg::spm_in_t              in_data_i,
  input  wire logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  input  wire spm_pkg::spm_out_t             out_data_o,
  input  wire logic                          cfg_valid_i,
  input  wire logic                          cfg_ready_o,
  input  wire logic [spm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [spm_pkg::CfgDataW-1:0]  cfg_data_i
);
  import spm_pkg::*;

  // Stalled output transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped under stall");

  // Stalled output payload holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed under stall");

  // Input stall only rises after an input transaction filled the buffer
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall without a buffered transaction");

  // Nothing comes out and the input is not stalled the cycle reset is released
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("activity right after reset");

endmodule

bind stream_pattern_masker spm_checker u_spm_checker (.*);

`default_nettype wire
